>>> rtl/fdi_pkg.sv
package fdi_pkg;

  localparam int WEIGHT_FRACTION_BITS_DEF = 12;

  localparam int GLU_W   = 13;
  localparam int RATE_W  = 11;
  localparam int CARB_W  = 11;
  localparam int DOSE_W  = 12;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam int RULE_COUNT = 13;
  localparam int RAMP_COUNT = 8;
  localparam int MEMB_COUNT = 9;

  // Membership slots. The first eight are ramp-based, the last one is exact.
  localparam int MB_GL = 0;
  localparam int MB_GN = 1;
  localparam int MB_GH = 2;
  localparam int MB_RF = 3;
  localparam int MB_RR = 4;
  localparam int MB_CS = 5;
  localparam int MB_CM = 6;
  localparam int MB_CG = 7;
  localparam int MB_RS = 8;

  typedef logic [1:0] cons_kind_t;
  localparam cons_kind_t CONS_LOW  = 2'd0;
  localparam cons_kind_t CONS_MOD  = 2'd1;
  localparam cons_kind_t CONS_HIGH = 2'd2;

  localparam cons_kind_t RULE_KIND [RULE_COUNT] = '{
    CONS_LOW, CONS_MOD, CONS_HIGH, CONS_HIGH, CONS_MOD, CONS_HIGH, CONS_LOW,
    CONS_LOW, CONS_MOD, CONS_HIGH, CONS_HIGH, CONS_LOW, CONS_MOD
  };

  // Each ramp span is 2**RAMP_K times an odd divisor RAMP_D.
  localparam int RAMP_K [RAMP_COUNT] = '{4, 5, 4, 8, 8, 4, 5, 4};
  localparam int RAMP_D [RAMP_COUNT] = '{75, 25, 75, 3, 3, 15, 15, 15};

endpackage

>>> rtl/fuzzy_dose_inference_top.sv
// Fuzzy insulin dose estimator. Each input beat carries glucose level, glucose rate and
// carbohydrate amount; each produces exactly one output beat with the dose (8 fraction bits)
// and a flag that is set, with the dose forced to 0, when no rule fires. The pipeline takes
// one beat per clock unless it is full and the output stalled. It has 7 stages of membership,
// rule and sum logic, then a 12-stage restoring divider resolving one quotient bit per stage.
// Stages advance independently, so bubbles close up while the output is stalled.
module fuzzy_dose_inference_top
  import fdi_pkg::*;
#(
  parameter int WEIGHT_FRACTION_BITS = WEIGHT_FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // glucose_level [12:0], glucose_rate [23:13], carb_amount [34:24], zero fill above
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // dose [11:0], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // no_rule_fired [0]
  output logic                   out_tuser
);

  localparam int W      = WEIGHT_FRACTION_BITS;
  localparam int MBW    = W + 1;            // membership, 0..1.0
  localparam int NW     = 11;               // ramp numerator
  localparam int DW     = W + 7;            // shifted ramp dividend
  localparam int SH     = DW + 7;           // reciprocal scale
  localparam int MW     = SH - 1;           // reciprocal width
  localparam int PW     = DW + MW;          // ramp product
  localparam int ZW     = W + 4;            // consequent value, up to 12.0
  localparam int PRW    = MBW + ZW;         // weight times consequent
  localparam int NUM_W  = 2 * W + 8;
  localparam int DEN_W  = W + 4;
  localparam int RW     = NUM_W - (W - 8);  // divider remainder
  localparam int QW     = DOSE_W;
  localparam int NGRP   = 4;
  localparam int PRE_ST = 7;
  localparam int NST    = PRE_ST + QW;

  localparam logic [MW-1:0] M_75 = MW'(((64'd1 << SH) + 64'd74) / 64'd75);
  localparam logic [MW-1:0] M_25 = MW'(((64'd1 << SH) + 64'd24) / 64'd25);
  localparam logic [MW-1:0] M_3  = MW'(((64'd1 << SH) + 64'd2) / 64'd3);
  localparam logic [MW-1:0] M_15 = MW'(((64'd1 << SH) + 64'd14) / 64'd15);
  localparam logic [MW-1:0] RAMP_M [RAMP_COUNT] =
    '{M_75, M_25, M_75, M_3, M_3, M_15, M_15, M_15};

  localparam logic [MBW-1:0] ONE_W = MBW'(1) << W;

  function automatic logic [MBW-1:0] mn(input logic [MBW-1:0] a, input logic [MBW-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [MBW-1:0] mx(input logic [MBW-1:0] a, input logic [MBW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic [NST:0]   en;
  logic [NST-1:0] v_r, v_nxt;

  always_comb begin
    en[NST] = out_tready;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
    v_nxt[0] = en[0] ? in_tvalid : v_r[0];
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        v_nxt[k] = v_r[k-1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = en[0];

  // Stage 1: range decode and ramp numerators.
  logic [GLU_W-1:0]         g;
  logic signed [RATE_W-1:0] r;
  logic signed [RATE_W:0]   r_ext, r_neg;
  logic [CARB_W-1:0]        c;
  logic [NW-1:0]            n_nxt [RAMP_COUNT];
  logic [RAMP_COUNT-1:0]    one_nxt, ramp_nxt;
  logic [8:0]               rs_nxt;
  logic [NW-1:0]            n1_r [RAMP_COUNT];
  logic [RAMP_COUNT-1:0]    one1_r, ramp1_r;
  logic [8:0]               rs1_r;

  assign g     = in_tdata[12:0];
  assign r     = in_tdata[23:13];
  assign c     = in_tdata[34:24];
  assign r_ext = {r[RATE_W-1], r};
  assign r_neg = -r_ext;

  always_comb begin
    for (int i = 0; i < RAMP_COUNT; i++) begin
      n_nxt[i] = '0;
    end
    one_nxt  = '0;
    ramp_nxt = '0;
    rs_nxt   = '0;

    if (g <= 13'd800) begin
      one_nxt[MB_GL] = 1'b1;
    end else if (g < 13'd2000) begin
      ramp_nxt[MB_GL] = 1'b1;
      n_nxt[MB_GL]    = NW'(13'd2000 - g);
    end

    if (g > 13'd800 && g < 13'd1600) begin
      ramp_nxt[MB_GN] = 1'b1;
      n_nxt[MB_GN]    = NW'(g - 13'd800);
    end else if (g >= 13'd1600 && g <= 13'd2400) begin
      one_nxt[MB_GN] = 1'b1;
    end else if (g > 13'd2400 && g < 13'd3200) begin
      ramp_nxt[MB_GN] = 1'b1;
      n_nxt[MB_GN]    = NW'(13'd3200 - g);
    end

    if (g > 13'd2000 && g < 13'd3200) begin
      ramp_nxt[MB_GH] = 1'b1;
      n_nxt[MB_GH]    = NW'(g - 13'd2000);
    end else if (g >= 13'd3200) begin
      one_nxt[MB_GH] = 1'b1;
    end

    if (r > -11'sd768 && r <= 11'sd0) begin
      ramp_nxt[MB_RF] = 1'b1;
      n_nxt[MB_RF]    = r_neg[NW-1:0];
    end
    if (r > 11'sd0 && r <= 11'sd768) begin
      ramp_nxt[MB_RR] = 1'b1;
      n_nxt[MB_RR]    = r_ext[NW-1:0];
    end

    if (r > -11'sd256 && r < 11'sd0) begin
      rs_nxt = 9'(r_ext + 12'sd256);
    end else if (r >= 11'sd0 && r < 11'sd256) begin
      rs_nxt = 9'(12'sd256 - r_ext);
    end

    if (c <= 11'd240) begin
      one_nxt[MB_CS] = 1'b1;
    end else if (c < 11'd480) begin
      ramp_nxt[MB_CS] = 1'b1;
      n_nxt[MB_CS]    = NW'(11'd480 - c);
    end

    if (c >= 11'd320 && c < 11'd800) begin
      ramp_nxt[MB_CM] = 1'b1;
      n_nxt[MB_CM]    = NW'(c - 11'd320);
    end else if (c >= 11'd800 && c < 11'd1280) begin
      ramp_nxt[MB_CM] = 1'b1;
      n_nxt[MB_CM]    = NW'(11'd1280 - c);
    end

    if (c >= 11'd1120 && c < 11'd1360) begin
      ramp_nxt[MB_CG] = 1'b1;
      n_nxt[MB_CG]    = NW'(c - 11'd1120);
    end else if (c >= 11'd1360 && c <= 11'd1600) begin
      one_nxt[MB_CG] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n1_r    <= n_nxt;
      one1_r  <= one_nxt;
      ramp1_r <= ramp_nxt;
      rs1_r   <= rs_nxt;
    end
  end

  // Stage 2: divide by the odd part of each span as an exact reciprocal multiply.
  logic [PW-1:0]         p2_r [RAMP_COUNT];
  logic [RAMP_COUNT-1:0] one2_r, ramp2_r;
  logic [8:0]            rs2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < RAMP_COUNT; i++) begin
        p2_r[i] <= PW'((DW'(n1_r[i]) << (W - RAMP_K[i])) * RAMP_M[i]);
      end
      one2_r  <= one1_r;
      ramp2_r <= ramp1_r;
      rs2_r   <= rs1_r;
    end
  end

  // Stage 3: memberships.
  logic [MBW-1:0] mb3_r [MEMB_COUNT];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < RAMP_COUNT; i++) begin
        if (ramp2_r[i]) begin
          mb3_r[i] <= p2_r[i][SH +: MBW];
        end else if (one2_r[i]) begin
          mb3_r[i] <= ONE_W;
        end else begin
          mb3_r[i] <= '0;
        end
      end
      mb3_r[MB_RS] <= MBW'(rs2_r) << (W - 8);
    end
  end

  // Stage 4: rule weights.
  logic [MBW-1:0] w4_r [RULE_COUNT];
  logic [MBW-1:0] gl, gn, gh, rf, rs, rr, cs, cm, cg;

  assign gl = mb3_r[MB_GL];
  assign gn = mb3_r[MB_GN];
  assign gh = mb3_r[MB_GH];
  assign rf = mb3_r[MB_RF];
  assign rs = mb3_r[MB_RS];
  assign rr = mb3_r[MB_RR];
  assign cs = mb3_r[MB_CS];
  assign cm = mb3_r[MB_CM];
  assign cg = mb3_r[MB_CG];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      w4_r[0]  <= mn(mn(gl, rf), cs);
      w4_r[1]  <= mn(mn(gn, rs), cg);
      w4_r[2]  <= mn(gh, rs);
      w4_r[3]  <= mn(mn(gh, rr), cm);
      w4_r[4]  <= mn(gn, cm);
      w4_r[5]  <= mn(rr, cg);
      w4_r[6]  <= mn(mn(gl, rs), cg);
      w4_r[7]  <= mn(mn(gn, rr), cs);
      w4_r[8]  <= mn(mn(gh, rf), cg);
      w4_r[9]  <= mn(mn(gn, rr), cs);
      w4_r[10] <= mx(gh, rr);
      w4_r[11] <= mx(gl, rf);
      w4_r[12] <= mx(mn(gn, rr), cs);
    end
  end

  // Stage 5: consequent values and weighted terms. A zero weight adds nothing to either sum.
  logic [PRW-1:0] pr5_r [RULE_COUNT];
  logic [MBW-1:0] w5_r  [RULE_COUNT];
  logic [ZW-1:0]  z     [RULE_COUNT];

  always_comb begin
    for (int i = 0; i < RULE_COUNT; i++) begin
      case (RULE_KIND[i])
        CONS_LOW:  z[i] = (ZW'(ONE_W) << 2) - (ZW'(w4_r[i]) << 2);
        CONS_MOD:  z[i] = ZW'(ONE_W) * ZW'(6);
        default:   z[i] = (ZW'(w4_r[i]) << 2) + (ZW'(ONE_W) << 3);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < RULE_COUNT; i++) begin
        pr5_r[i] <= PRW'(w4_r[i]) * PRW'(z[i]);
        w5_r[i]  <= w4_r[i];
      end
    end
  end

  // Stage 6: partial sums over groups of up to four rules.
  logic [NUM_W-1:0] num6_r [NGRP];
  logic [DEN_W-1:0] den6_r [NGRP];
  logic [NUM_W-1:0] num6_nxt [NGRP];
  logic [DEN_W-1:0] den6_nxt [NGRP];

  always_comb begin
    for (int gi = 0; gi < NGRP; gi++) begin
      num6_nxt[gi] = '0;
      den6_nxt[gi] = '0;
    end
    for (int i = 0; i < RULE_COUNT; i++) begin
      num6_nxt[i / 4] = num6_nxt[i / 4] + NUM_W'(pr5_r[i]);
      den6_nxt[i / 4] = den6_nxt[i / 4] + DEN_W'(w5_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      num6_r <= num6_nxt;
      den6_r <= den6_nxt;
    end
  end

  // Stage 7: totals. The numerator drops the fraction bits the quotient does not keep.
  logic [NUM_W-1:0] num7_nxt;
  logic [DEN_W-1:0] den7_nxt;
  logic [RW-1:0]    rem7_r;
  logic [DEN_W-1:0] den7_r;
  logic             nf7_r;

  assign num7_nxt = num6_r[0] + num6_r[1] + num6_r[2] + num6_r[3];
  assign den7_nxt = den6_r[0] + den6_r[1] + den6_r[2] + den6_r[3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rem7_r <= num7_nxt[NUM_W-1 -: RW];
      den7_r <= den7_nxt;
      nf7_r  <= (den7_nxt == '0);
    end
  end

  // Restoring divider, most significant quotient bit first.
  logic [RW-1:0]    rem_r [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [QW-1:0]    q_r   [QW];
  logic             nf_r  [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [RW-1:0]    rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QW-1:0]    q_in;
    logic             nf_in;
    logic [RW:0]      diff;

    if (j == 0) begin : g_first
      assign rem_in = rem7_r;
      assign den_in = den7_r;
      assign q_in   = '0;
      assign nf_in  = nf7_r;
    end else begin : g_next
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign q_in   = q_r[j-1];
      assign nf_in  = nf_r[j-1];
    end

    assign diff = {1'b0, rem_in} - ((RW + 1)'(den_in) << (QW - 1 - j));

    always_ff @(posedge clk) begin
      if (en[PRE_ST + j]) begin
        rem_r[j] <= diff[RW] ? rem_in : diff[RW-1:0];
        q_r[j]   <= {q_in[QW-2:0], ~diff[RW]};
        den_r[j] <= den_in;
        nf_r[j]  <= nf_in;
      end
    end
  end

  assign out_tvalid = v_r[NST-1];
  assign out_tuser  = nf_r[QW-1];
  assign out_tdata  = nf_r[QW-1] ? '0 : OUT_TDATA_W'(q_r[QW-1]);

endmodule
